// File: src/ial_pkg.sv
package ial_pkg;

  // field widths of one word on each channel
  localparam int FUNC_W      = 3;
  localparam int POS_W       = 11;
  localparam int WORD_W      = 32;
  localparam int STAT_W      = 2;
  localparam int CNT_OUT_W   = 11;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (WORD_W + STAT_W + CNT_OUT_W);

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_GET    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_SET    = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BOUNDS = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_LAST,
    S_REM_GOT,
    S_REM,
    S_GET,
    S_DONE
  } ial_state_t;

  // one finished result word
  typedef struct packed {
    logic [CNT_OUT_W-1:0] count;
    logic [STAT_W-1:0]    status;
    logic [WORD_W-1:0]    word;
  } ial_res_t;

endpackage

// File: src/ial_store.sv
module ial_store #(
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [ial_pkg::WORD_W-1:0] wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [ial_pkg::WORD_W-1:0] rdata
);

  logic [ial_pkg::WORD_W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/ial_seq.sv
module ial_seq #(
  parameter int CAPACITY = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ial_pkg::FUNC_W-1:0]    in_func,
  input  logic [ial_pkg::POS_W-1:0]     in_position,
  input  logic [ial_pkg::WORD_W-1:0]    in_word,
  output logic                          res_valid,
  input  logic                          res_ready,
  output ial_pkg::ial_res_t             res,
  output logic                          mem_we,
  output logic [$clog2(CAPACITY)-1:0]   mem_waddr,
  output logic [ial_pkg::WORD_W-1:0]    mem_wdata,
  output logic                          mem_re,
  output logic [$clog2(CAPACITY)-1:0]   mem_raddr,
  input  logic [ial_pkg::WORD_W-1:0]    mem_rdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > ial_pkg::POS_W) ? CW : ial_pkg::POS_W;
  localparam int XW = EW + 1;

  ial_pkg::ial_state_t state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [AW-1:0]              cur_r, cur_nxt;
  logic [AW-1:0]              pos_r, pos_nxt;
  logic [ial_pkg::WORD_W-1:0] word_r, word_nxt;
  logic [ial_pkg::WORD_W-1:0] res_word_r, res_word_nxt;
  logic [ial_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic                       inc_r, inc_nxt;
  logic                       dec_r, dec_nxt;

  // widened views for index checks
  logic [XW-1:0] pos_e, cnt_e, ins_tgt, rem_tgt;
  logic [CW-1:0] cnt_m1, count_new;
  logic [AW-1:0] cur_m1;
  logic          full;

  assign pos_e   = XW'(in_position);
  assign cnt_e   = XW'(count_r);
  assign ins_tgt = (in_func == ial_pkg::FN_PUSH) ? cnt_e : pos_e;
  assign rem_tgt = (in_func == ial_pkg::FN_POP) ? (cnt_e - XW'(1)) : pos_e;
  assign cnt_m1  = count_r - CW'(1);
  assign cur_m1  = cur_r - AW'(1);
  assign full    = (count_r == CW'(CAPACITY));

  // length after the finished operation
  always_comb begin
    count_new = count_r;
    if (inc_r) begin
      count_new = count_r + CW'(1);
    end else if (dec_r) begin
      count_new = count_r - CW'(1);
    end
  end

  assign in_ready   = (state_r == ial_pkg::S_IDLE);
  assign res_valid  = (state_r == ial_pkg::S_DONE);
  assign res.word   = res_word_r;
  assign res.status = res_status_r;
  assign res.count  = ial_pkg::CNT_OUT_W'(count_new);

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ial_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // per-operation working registers
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    pos_r        <= pos_nxt;
    word_r       <= word_nxt;
    res_word_r   <= res_word_nxt;
    res_status_r <= res_status_nxt;
    inc_r        <= inc_nxt;
    dec_r        <= dec_nxt;
  end

  // sequencer: decode, shift loop over the store, hand off the result
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    pos_nxt        = pos_r;
    word_nxt       = word_r;
    res_word_nxt   = res_word_r;
    res_status_nxt = res_status_r;
    inc_nxt        = inc_r;
    dec_nxt        = dec_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    unique case (state_r)
      ial_pkg::S_IDLE: begin
        if (in_valid) begin
          word_nxt       = in_word;
          pos_nxt        = pos_e[AW-1:0];
          inc_nxt        = 1'b0;
          dec_nxt        = 1'b0;
          res_word_nxt   = '0;
          res_status_nxt = ial_pkg::ST_OK;
          state_nxt      = ial_pkg::S_DONE;
          unique case (in_func) inside
            ial_pkg::FN_INSERT, ial_pkg::FN_PUSH: begin
              pos_nxt = ins_tgt[AW-1:0];
              if (ins_tgt > cnt_e) begin
                res_status_nxt = ial_pkg::ST_BOUNDS;
              end else if (full) begin
                res_status_nxt = ial_pkg::ST_FULL;
              end else begin
                res_word_nxt = in_word;
                inc_nxt      = 1'b1;
                if (ins_tgt == cnt_e) begin
                  // append: no entries to move
                  mem_we    = 1'b1;
                  mem_waddr = ins_tgt[AW-1:0];
                  mem_wdata = in_word;
                end else begin
                  // start moving entries up from the tail
                  mem_re    = 1'b1;
                  mem_raddr = cnt_m1[AW-1:0];
                  cur_nxt   = count_r[AW-1:0];
                  state_nxt = ial_pkg::S_INS;
                end
              end
            end
            ial_pkg::FN_REMOVE, ial_pkg::FN_POP: begin
              pos_nxt = rem_tgt[AW-1:0];
              if (count_r == '0) begin
                res_status_nxt = ial_pkg::ST_EMPTY;
              end else if (rem_tgt >= cnt_e) begin
                res_status_nxt = ial_pkg::ST_BOUNDS;
              end else begin
                dec_nxt   = 1'b1;
                mem_re    = 1'b1;
                mem_raddr = rem_tgt[AW-1:0];
                state_nxt = ial_pkg::S_REM_GOT;
              end
            end
            ial_pkg::FN_GET: begin
              if (pos_e >= cnt_e) begin
                res_status_nxt = ial_pkg::ST_BOUNDS;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = pos_e[AW-1:0];
                state_nxt = ial_pkg::S_GET;
              end
            end
            ial_pkg::FN_SET: begin
              if (pos_e >= cnt_e) begin
                res_status_nxt = ial_pkg::ST_BOUNDS;
              end else begin
                res_word_nxt = in_word;
                mem_we       = 1'b1;
                mem_waddr    = pos_e[AW-1:0];
                mem_wdata    = in_word;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // move one entry up per cycle, next read overlaps this write
      ial_pkg::S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = mem_rdata;
        if (cur_m1 > pos_r) begin
          mem_re    = 1'b1;
          mem_raddr = cur_r - AW'(2);
          cur_nxt   = cur_m1;
        end else begin
          state_nxt = ial_pkg::S_INS_LAST;
        end
      end

      // drop the new word into the opened slot
      ial_pkg::S_INS_LAST: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = word_r;
        state_nxt = ial_pkg::S_DONE;
      end

      // removed word is back, start closing the gap
      ial_pkg::S_REM_GOT: begin
        res_word_nxt = mem_rdata;
        cur_nxt      = pos_r;
        if ((XW'(pos_r) + XW'(1)) < cnt_e) begin
          mem_re    = 1'b1;
          mem_raddr = pos_r + AW'(1);
          state_nxt = ial_pkg::S_REM;
        end else begin
          state_nxt = ial_pkg::S_DONE;
        end
      end

      // move one entry down per cycle
      ial_pkg::S_REM: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = mem_rdata;
        if ((XW'(cur_r) + XW'(2)) < cnt_e) begin
          mem_re    = 1'b1;
          mem_raddr = cur_r + AW'(2);
          cur_nxt   = cur_r + AW'(1);
        end else begin
          state_nxt = ial_pkg::S_DONE;
        end
      end

      ial_pkg::S_GET: begin
        res_word_nxt = mem_rdata;
        state_nxt    = ial_pkg::S_DONE;
      end

      // wait for the output register, then commit the length
      ial_pkg::S_DONE: begin
        if (res_ready) begin
          count_nxt = count_new;
          state_nxt = ial_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ial_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: src/indexed_array_list_unit.sv
// indexed array list: one request word in, one result word out, one request at a time
// set, push, insert at the end, get and rejected requests move no entries in the store;
// insert before the end and remove move every entry behind the position, one entry per cycle
// next request taken the cycle after the result enters the output register
// reset clears the length and the handshake state; the store is not cleared
module indexed_array_list_unit #(
  parameter int CAPACITY = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // func [2:0], position [13:3], word_in [45:14], zero pad above
  input  logic [ial_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // word_out [31:0], status [33:32], count [44:34], zero pad above
  output logic [ial_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int AW = $clog2(CAPACITY);

  logic                       res_valid, res_ready;
  ial_pkg::ial_res_t          res;
  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [ial_pkg::WORD_W-1:0] mem_wdata, mem_rdata;

  logic              out_tvalid_r, out_tvalid_nxt;
  ial_pkg::ial_res_t out_res_r;

  ial_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_func    (in_tdata[2:0]),
    .in_position(in_tdata[13:3]),
    .in_word    (in_tdata[45:14]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  ial_store #(
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // output register takes a result when empty or being drained
  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (res_valid && res_ready) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{ial_pkg::OUT_PAD_W{1'b0}}, out_res_r};

endmodule
